/* src/modbus_reply_checker_macros.svh */
// ----------------------------------------------------------------------------
// Modbus reply checker assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_REPLY_CHECKER_MACROS_SVH
`define MODBUS_REPLY_CHECKER_MACROS_SVH

// same-cycle implication
`define MBRC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// mbrc_pkg
// Types, codes and the CRC-16 byte update for the Modbus reply checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

   localparam int MAX_FRAME = 256;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);
   localparam int HEAD_N    = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FC_MASK = 8'h7F;
   localparam logic [7:0] EX_FLAG = 8'h80;

   // function codes
   localparam logic [6:0] FC_READ_HOLDING = 7'd3;
   localparam logic [6:0] FC_READ_INPUT   = 7'd4;
   localparam logic [6:0] FC_WRITE_SINGLE = 7'd6;
   localparam logic [6:0] FC_WRITE_MULTI  = 7'd16;

   // status codes
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_SHORT      = 4'd1;
   localparam logic [3:0] ST_CRC        = 4'd2;
   localparam logic [3:0] ST_DEVICE     = 4'd3;
   localparam logic [3:0] ST_FUNCTION   = 4'd4;
   localparam logic [3:0] ST_GENERIC    = 4'd5;
   localparam logic [3:0] ST_EXC_LAST   = 4'd9;

   localparam logic [7:0] EXC_MIN = 8'd1;
   localparam logic [7:0] EXC_MAX = 8'd4;
   localparam int         MIN_LEN = 5;

   // csr register indexes
   localparam logic [2:0] CSR_DEVICE_ADDRESS   = 3'd0;
   localparam logic [2:0] CSR_FUNCTION_CODE    = 3'd1;
   localparam logic [2:0] CSR_REGISTER_ADDRESS = 3'd2;
   localparam logic [2:0] CSR_REGISTER_COUNT   = 3'd3;
   localparam logic [2:0] CSR_WRITE_VALUE      = 3'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [3:0] status;
      logic [7:0] exception_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  device_address;
      logic [6:0]  function_code;
      logic [15:0] register_address;
      logic [6:0]  register_count;
      logic [15:0] write_value;
   } cfg_type;

   // frame after the current word has been folded in
   typedef struct packed {
      logic [HEAD_N-1:0][7:0] head;
      logic [CNT_W-1:0]       count;
      logic [15:0]            crc;
   } frame_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* src/mbrc_frame.sv */
// ----------------------------------------------------------------------------
// mbrc_frame
// Per-frame accumulator: running CRC, byte count and the first six bytes.
// ----------------------------------------------------------------------------
module mbrc_frame import mbrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      take,
   input  req_type   word,
   output frame_type frame
);

   logic [HEAD_N-1:0][7:0] head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [15:0]            crc_ff, crc_in;
   logic                   keep;

   // bytes past the buffer size are dropped, end mark still closes the frame
   assign keep = (count_ff < CNT_W'(MAX_FRAME));

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      if (keep) begin
         for (int i = 0; i < HEAD_N; i++) begin
            if (count_ff == CNT_W'(i)) begin
               head_in[i] = word.rx_byte;
            end
         end
         crc_in   = crc_update(crc_ff, word.rx_byte);
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign frame.head  = head_in;
   assign frame.count = count_in;
   assign frame.crc   = crc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else if (take) begin
         if (word.frame_end) begin
            head_ff  <= '0;
            count_ff <= '0;
            crc_ff   <= CRC_INIT;
         end else begin
            head_ff  <= head_in;
            count_ff <= count_in;
            crc_ff   <= crc_in;
         end
      end
   end

endmodule

/* src/mbrc_eval.sv */
// ----------------------------------------------------------------------------
// mbrc_eval
// Checks a closed frame against the request and holds the result word.
// ----------------------------------------------------------------------------
module mbrc_eval import mbrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  frame_type frame,
   input  cfg_type   cfg,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [6:0] fun;
   logic [7:0] code;
   logic       is_exc;
   logic [15:0] reg_echo, val_echo;

   assign fun      = 7'(frame.head[1] & FC_MASK);
   assign is_exc   = |(frame.head[1] & EX_FLAG);
   assign code     = frame.head[2];
   assign reg_echo = {frame.head[2], frame.head[3]} + 16'd1;
   assign val_echo = {frame.head[4], frame.head[5]};

   always_comb begin
      rsp_data_in.exception_code = '0;
      rsp_data_in.status         = ST_GENERIC;
      if (frame.count < CNT_W'(MIN_LEN)) begin
         rsp_data_in.status = ST_SHORT;
      end else if (frame.crc != '0) begin
         rsp_data_in.status = ST_CRC;
      end else if (frame.head[0] != cfg.device_address) begin
         rsp_data_in.status = ST_DEVICE;
      end else if (fun != cfg.function_code) begin
         rsp_data_in.status = ST_FUNCTION;
      end else if (is_exc) begin
         rsp_data_in.exception_code = code;
         if (code inside {[EXC_MIN:EXC_MAX]}) begin
            rsp_data_in.status = ST_GENERIC + code[3:0];
         end
      end else begin
         case (fun)
            FC_READ_HOLDING, FC_READ_INPUT: begin
               if (code[7:1] == cfg.register_count) begin
                  rsp_data_in.status = ST_OK;
               end
            end
            FC_WRITE_SINGLE: begin
               if (reg_echo == cfg.register_address && val_echo == cfg.write_value) begin
                  rsp_data_in.status = ST_OK;
               end
            end
            FC_WRITE_MULTI: begin
               if (reg_echo == cfg.register_address &&
                   val_echo == {9'd0, cfg.register_count}) begin
                  rsp_data_in.status = ST_OK;
               end
            end
            default: rsp_data_in.status = ST_GENERIC;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/modbus_reply_checker.sv */
// ----------------------------------------------------------------------------
// modbus_reply_checker
// Result: the result word is registered when the frame's closing byte leaves the input register.
// Throughput: one byte per cycle while req_stall is low; the input register frees as the byte is folded in.
// A closing byte waits in the input register only while a result is held stalled.
// Reset: synchronous; clears handshake state and frame count/head, sets the frame CRC to CRC_INIT, loads CSR defaults.
// Checks one Modbus RTU reply (length, CRC-16, address, function, exception, echo) against the request.
// ----------------------------------------------------------------------------
module modbus_reply_checker import mbrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

`include "modbus_reply_checker_macros.svh"

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff;
   logic      accept, advance, load;
   cfg_type   cfg_ff;
   frame_type frame;

   // a closing word may only move on when the result register is free
   assign advance   = in_valid_ff && (!in_data_ff.frame_end || !rsp_valid || !rsp_stall);
   assign load      = advance && in_data_ff.frame_end;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address   <= 8'd1;
         cfg_ff.function_code    <= FC_READ_HOLDING;
         cfg_ff.register_address <= 16'd1;
         cfg_ff.register_count   <= 7'd1;
         cfg_ff.write_value      <= 16'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:   cfg_ff.device_address   <= csr_wdata[7:0];
            CSR_FUNCTION_CODE:    cfg_ff.function_code    <= csr_wdata[6:0];
            CSR_REGISTER_ADDRESS: cfg_ff.register_address <= csr_wdata;
            CSR_REGISTER_COUNT:   cfg_ff.register_count   <= csr_wdata[6:0];
            CSR_WRITE_VALUE:      cfg_ff.write_value      <= csr_wdata;
            default: ;
         endcase
      end
   end

   mbrc_frame u_frame (
      .clock (clock),
      .reset (reset),
      .take  (advance),
      .word  (in_data_ff),
      .frame (frame)
   );

   mbrc_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .frame     (frame),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `MBRC_ASSERT_NOW(a_stall_needs_word, req_stall, in_valid_ff && in_data_ff.frame_end, "stall without a held closing word")
   `MBRC_ASSERT_NOW(a_mid_word_flows, in_valid_ff && !in_data_ff.frame_end, advance, "mid-frame word blocked")
   `MBRC_ASSERT_NEXT(a_load_shows, load, rsp_valid, "loaded result not presented")
   `MBRC_ASSERT_NOW(a_excode_status, rsp_valid && rsp_data.exception_code != 8'd0, rsp_data.status >= ST_GENERIC && rsp_data.status <= ST_EXC_LAST, "exception code on a non-exception status")

endmodule
